// ----- hw/rtl/stpm_pkg.sv -----
// Shared constants, types and register codes of the swap-tolerant pattern matcher.
package stpm_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int MAX_TEXT = 4096;

	localparam int CHAR_W = 8;
	localparam int LEN_W = 5;
	localparam int START_W = 12;
	localparam int POS_W = $clog2(MAX_TEXT + 1);
	localparam int IDX_W = $clog2(MAX_PATTERN);

	localparam int APB_W = 64;
	localparam int ADDR_W = 5;
	localparam int REG_W = 2;

	localparam logic [REG_W-1:0] REG_PAT_LEN = 2'd0;
	localparam logic [REG_W-1:0] REG_CHARS_LO = 2'd1;
	localparam logic [REG_W-1:0] REG_CHARS_HI = 2'd2;

	typedef struct packed {
		logic [LEN_W-1:0] pat_len;
		logic [APB_W-1:0] chars_hi;
		logic [APB_W-1:0] chars_lo;
	} cfg_t;

	// Token handed from cell to cell during the greedy pass
	typedef struct packed {
		logic valid;
		logic used_prev;
		logic used_cur;
	} tok_t;

	// Controls broadcast to every cell
	typedef struct packed {
		logic shift;
		logic [CHAR_W-1:0] pchar;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/stpm_cfg.sv -----
// APB register file holding the pattern length and pattern characters.
module stpm_cfg
	import stpm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [LEN_W-1:0] pat_len_q;
	logic [APB_W-1:0] chars_lo_q;
	logic [APB_W-1:0] chars_hi_q;
	logic [REG_W-1:0] reg_sel;
	logic             wr_en;

	assign pready = 1'b1;
	assign reg_sel = paddr[ADDR_W-1:ADDR_W-REG_W];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= LEN_W'(1);
			chars_lo_q <= '0;
			chars_hi_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_PAT_LEN: pat_len_q <= pwdata[LEN_W-1:0];
				REG_CHARS_LO: chars_lo_q <= pwdata;
				REG_CHARS_HI: chars_hi_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_PAT_LEN: prdata = APB_W'(pat_len_q);
			REG_CHARS_LO: prdata = chars_lo_q;
			REG_CHARS_HI: prdata = chars_hi_q;
			default: prdata = '0;
		endcase
	end

	assign cfg.pat_len = pat_len_q;
	assign cfg.chars_lo = chars_lo_q;
	assign cfg.chars_hi = chars_hi_q;

endmodule

// ----- hw/rtl/stpm_cell.sv -----
// One window cell: holds a text byte and evaluates one pattern character when the token arrives.
module stpm_cell
	import stpm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic              inject,
	input  logic [CHAR_W-1:0] in_byte,
	input  logic [CHAR_W-1:0] up_byte,
	input  logic [CHAR_W-1:0] down_byte,
	input  logic              has_down,
	input  tok_t              tok_in,
	output logic [CHAR_W-1:0] byte_q,
	output tok_t              tok_q
);

	logic active;
	logic prev_used;
	logic cur_used;
	logic take_cur;
	logic take_prev;
	logic take_next;

	assign active = inject | tok_in.valid;
	assign prev_used = inject | tok_in.used_prev;
	assign cur_used = ~inject & tok_in.used_cur;

	assign take_cur = ~cur_used & (byte_q == ctl.pchar);
	assign take_prev = ~take_cur & ~prev_used & (up_byte == ctl.pchar);
	assign take_next = ~take_cur & ~take_prev & has_down & (down_byte == ctl.pchar);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			tok_q <= '0;
		end else begin
			if (ctl.shift) begin
				byte_q <= in_byte;
			end
			tok_q.valid <= active & (take_cur | take_prev | take_next);
			tok_q.used_prev <= cur_used | take_cur;
			tok_q.used_cur <= take_next;
		end
	end

endmodule

// ----- hw/rtl/swap_tolerant_pattern_matcher.sv -----
// Top level of the swap-tolerant pattern matcher: input control, cell chain, result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  input    | in_valid / in_stall  | text_char, first_char
//  result   | out_valid / out_stall| start_position
//  config   | APB psel / penable   | paddr, pwdata, prdata
//
// A byte that completes no window does not stall the input. A byte that completes a window
// keeps the input stalled while the token walks the cell chain one cell a cycle.
// Reset clears the window, the text position and the registers; no clearing pass.
// A waiting result does not block input by itself; a new match waits in the result
// holding register and keeps the input stalled until the stalled result leaves.
module swap_tolerant_pattern_matcher
	import stpm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CHAR_W-1:0]  text_char,
	input  logic               first_char,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [START_W-1:0] start_position,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	cfg_t               cfg;
	logic [1:0]         state_q;
	logic [POS_W-1:0]   pos_q;
	logic [LEN_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   k_q;
	logic [START_W-1:0] start_q;
	logic               out_valid_q;
	logic [START_W-1:0] out_pos_q;

	logic               in_acc;
	logic               take;
	logic [POS_W-1:0]   pos_cur;
	logic [POS_W:0]     pos_nxt;
	logic [LEN_W-1:0]   len_eff;
	logic [LEN_W-1:0]   len_m1;
	logic               eval_go;
	logic               out_free;
	logic               load_out;
	logic               match;
	logic [2*APB_W-1:0] chars_all;
	cell_ctl_t          ctl;
	logic [MAX_PATTERN-1:0] inj_vec;
	logic [CHAR_W-1:0]  win [MAX_PATTERN];
	tok_t               tok [MAX_PATTERN];

	stpm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid & ~in_stall;
	assign take = in_acc & (first_char | (pos_q < POS_W'(MAX_TEXT)));
	assign pos_cur = first_char ? '0 : pos_q;
	assign pos_nxt = {1'b0, pos_cur} + 1'b1;

	assign len_eff = (cfg.pat_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : cfg.pat_len;
	assign len_m1 = len_eff - 1'b1;
	assign eval_go = take & (len_eff != '0) & (pos_nxt >= (POS_W + 1)'(len_eff));

	assign chars_all = {cfg.chars_hi, cfg.chars_lo};
	assign ctl.shift = take;
	assign ctl.pchar = chars_all[k_q * CHAR_W +: CHAR_W];

	always_comb begin
		inj_vec = '0;
		if (state_q == ST_EVAL && cnt_q != '0 && k_q == '0) begin
			inj_vec[len_m1[IDX_W-1:0]] = 1'b1;
		end
	end

	genvar j;
	generate
		for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
			logic [CHAR_W-1:0] in_byte;
			logic [CHAR_W-1:0] up_byte;
			logic [CHAR_W-1:0] down_byte;
			tok_t              tok_in;

			if (j == 0) begin : g_first
				assign in_byte = text_char;
				assign down_byte = '0;
			end else begin : g_rest
				assign in_byte = first_char ? '0 : win[j-1];
				assign down_byte = win[j-1];
			end

			if (j == MAX_PATTERN - 1) begin : g_top
				assign up_byte = '0;
				assign tok_in = '0;
			end else begin : g_mid
				assign up_byte = win[j+1];
				assign tok_in = tok[j+1];
			end

			stpm_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.inject    (inj_vec[j]),
				.in_byte   (in_byte),
				.up_byte   (up_byte),
				.down_byte (down_byte),
				.has_down  (j != 0),
				.tok_in    (tok_in),
				.byte_q    (win[j]),
				.tok_q     (tok[j])
			);
		end
	endgenerate

	assign match = tok[0].valid;
	assign out_free = ~out_valid_q | ~out_stall;
	assign load_out = out_free &
		(((state_q == ST_EVAL) && (cnt_q == '0) && match) || (state_q == ST_HOLD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			cnt_q <= '0;
			k_q <= '0;
		end else begin
			if (take) begin
				pos_q <= pos_nxt[POS_W-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (eval_go) begin
						state_q <= ST_EVAL;
						cnt_q <= len_eff;
						k_q <= '0;
					end
				end
				ST_EVAL: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
						k_q <= k_q + 1'b1;
					end else if (!match || out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			start_q <= START_W'(pos_nxt - (POS_W + 1)'(len_eff));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pos_q <= start_q;
		end
	end

	assign out_valid = out_valid_q;
	assign start_position = out_pos_q;

endmodule

// ----- hw/rtl/stpm_checker.sv -----
// Port-level checks of the swap-tolerant pattern matcher, bound to the top level.
module stpm_checker
	import stpm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [START_W-1:0] start_position
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(start_position))
		else $error("result transaction changed while stalled");

	a_rise_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a search pass");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stalled without an accepted transaction");

endmodule

bind swap_tolerant_pattern_matcher stpm_checker u_stpm_checker (.*);

// ----- test/tb_swap_tolerant_pattern_matcher.sv -----
// Testbench of the swap-tolerant pattern matcher: directed table, random texts, greedy window predictor.
module tb_swap_tolerant_pattern_matcher;
	import stpm_pkg::*;

	typedef enum logic [1:0] {ROW_WRITE, ROW_PRED, ROW_NONE, ROW_AT} row_kind_e;
	typedef enum logic [1:0] {STALL_NONE, STALL_SCATTER, STALL_RUNS} stall_style_e;

	typedef struct packed {
		row_kind_e          kind;
		logic [REG_W-1:0]   idx;
		logic [APB_W-1:0]   value;
		logic [CHAR_W-1:0]  ch;
		logic               first;
		logic [START_W-1:0] at;
	} plan_row_t;

	localparam int PLAN_ROWS = 32;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_AT,    REG_PAT_LEN,  64'd0, 8'h00, 1'b1, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'hFF, 1'b0, 12'd0},
		'{ROW_AT,    REG_PAT_LEN,  64'd0, 8'h00, 1'b0, 12'd2},
		'{ROW_WRITE, REG_PAT_LEN,  64'd0, 8'h00, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h00, 1'b1, 12'd0},
		'{ROW_WRITE, REG_CHARS_LO, 64'h0000_0000_4443_4241, 8'h00, 1'b0, 12'd0},
		'{ROW_WRITE, REG_CHARS_HI, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 12'd0},
		'{ROW_WRITE, REG_PAT_LEN,  64'd4, 8'h00, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h42, 1'b1, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h41, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h43, 1'b0, 12'd0},
		'{ROW_AT,    REG_PAT_LEN,  64'd0, 8'h44, 1'b0, 12'd0},
		'{ROW_PRED,  REG_PAT_LEN,  64'd0, 8'h41, 1'b0, 12'd0},
		'{ROW_WRITE, REG_CHARS_LO, 64'h0706_0504_0302_0100, 8'h00, 1'b0, 12'd0},
		'{ROW_WRITE, REG_CHARS_HI, 64'h0F0E_0D0C_0B0A_0908, 8'h00, 1'b0, 12'd0},
		'{ROW_WRITE, REG_PAT_LEN,  64'd16, 8'h00, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h01, 1'b1, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h00, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h02, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h03, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h04, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h05, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h06, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h07, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h08, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h09, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h0A, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h0B, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h0C, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h0D, 1'b0, 12'd0},
		'{ROW_NONE,  REG_PAT_LEN,  64'd0, 8'h0F, 1'b0, 12'd0},
		'{ROW_AT,    REG_PAT_LEN,  64'd0, 8'h0E, 1'b0, 12'd0}
	};

	localparam int PHASES = 10;
	localparam logic [LEN_W-1:0] PHASE_LENS [PHASES] = '{
		5'd16, 5'd2, 5'd31, 5'd1, 5'd0, 5'd5, 5'd3, 5'd8, 5'd15, 5'd4
	};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [CHAR_W-1:0]  text_char = '0;
	logic               first_char = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [START_W-1:0] start_position;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [APB_W-1:0]   pwdata = '0;
	logic [APB_W-1:0]   prdata;
	logic               pready;

	swap_tolerant_pattern_matcher dut (.*);

	// predictor state
	logic [CHAR_W-1:0]  win [MAX_PATTERN];
	int                 text_pos;
	logic [LEN_W-1:0]   cfg_len;
	logic [APB_W-1:0]   cfg_lo;
	logic [APB_W-1:0]   cfg_hi;
	logic [START_W-1:0] pending_starts [$];

	// stimulus shaping
	logic [CHAR_W-1:0]  alpha [3];
	logic [CHAR_W-1:0]  pat [MAX_PATTERN];
	int                 alpha_n;
	int                 gen_len;
	int                 burst_left;
	bit                 holding;
	stall_style_e       stall_style = STALL_NONE;
	int                 stall_run;
	int                 stall_tick;

	int                 bad_count;
	int                 byte_count;
	int                 text_count;
	int                 start_count;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic note_mismatch(input string msg);
		bad_count++;
		if (bad_count <= 10) begin
			$display("mismatch: %s", msg);
		end
	endtask

	function automatic bit window_hit(int len);
		bit               taken [MAX_PATTERN];
		int               cand [3];
		int               n;
		int               k;
		int               j;
		int               p;
		bit               found;
		logic [CHAR_W-1:0] c;
		logic [APB_W-1:0] w;
		for (k = 0; k < MAX_PATTERN; k++) taken[k] = 1'b0;
		for (k = 0; k < len; k++) begin
			w = (k < 8) ? cfg_lo : cfg_hi;
			c = w[(k % 8) * 8 +: 8];
			cand[0] = k;
			n = 1;
			if (k > 0) begin
				cand[n] = k - 1;
				n++;
			end
			if (k == 0 || k < len - 1) begin
				cand[n] = k + 1;
				n++;
			end
			found = 1'b0;
			for (j = 0; j < n; j++) begin
				p = cand[j];
				if (!found && p < len && !taken[p] && win[len - 1 - p] == c) begin
					taken[p] = 1'b1;
					found = 1'b1;
				end
			end
			if (!found) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic track_char(input logic [CHAR_W-1:0] c, input logic first,
			output bit hit, output logic [START_W-1:0] where);
		int len;
		int i;
		hit = 1'b0;
		where = '0;
		if (first) begin
			for (i = 0; i < MAX_PATTERN; i++) win[i] = '0;
			text_pos = 0;
			text_count++;
		end
		if (text_pos >= MAX_TEXT) return;
		for (i = MAX_PATTERN - 1; i > 0; i--) win[i] = win[i - 1];
		win[0] = c;
		text_pos++;
		len = (cfg_len > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_len);
		if (len == 0 || text_pos < len) return;
		hit = window_hit(len);
		where = START_W'(text_pos - len);
	endtask

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic first,
			input row_kind_e how, input logic [START_W-1:0] at);
		bit                 hit;
		logic [START_W-1:0] where;
		int                 gap;
		in_valid <= 1'b1;
		text_char <= c;
		first_char <= first;
		holding = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		byte_count++;
		track_char(c, first, hit, where);
		case (how)
			ROW_AT: begin
				pending_starts.push_back(at);
			end
			ROW_PRED: begin
				if (hit) pending_starts.push_back(where);
			end
			default: begin
			end
		endcase
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
			in_valid <= 1'b0;
			holding = 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic wait_drained();
		if (holding) begin
			in_valid <= 1'b0;
			holding = 1'b0;
		end
		@(posedge clk);
		while (pending_starts.size() != 0) @(posedge clk);
		repeat (MAX_PATTERN + 4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [REG_W-1:0] idx, input logic [APB_W-1:0] v);
		logic [APB_W-1:0] shadow;
		shadow = '0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 3'b000});
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PAT_LEN: begin
				cfg_len = v[LEN_W-1:0];
				shadow = APB_W'(v[LEN_W-1:0]);
			end
			REG_CHARS_LO: begin
				cfg_lo = v;
				shadow = v;
			end
			REG_CHARS_HI: begin
				cfg_hi = v;
				shadow = v;
			end
			default: begin
			end
		endcase
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== shadow) begin
			note_mismatch($sformatf("register %0d read back: expected %0h, got %0h",
				idx, shadow, prdata));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_pattern(input logic [LEN_W-1:0] len_reg, input bit wide);
		logic [APB_W-1:0] lo;
		logic [APB_W-1:0] hi;
		int               i;
		int               eff;
		eff = (len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(len_reg);
		gen_len = (eff == 0) ? 4 : eff;
		alpha_n = wide ? 3 : 2;
		for (i = 0; i < 3; i++) alpha[i] = CHAR_W'($urandom);
		for (i = 0; i < MAX_PATTERN; i++) begin
			pat[i] = (i < gen_len) ? alpha[$urandom_range(0, alpha_n - 1)] : CHAR_W'($urandom);
		end
		for (i = 0; i < 8; i++) begin
			lo[i * 8 +: 8] = pat[i];
			hi[i * 8 +: 8] = pat[i + 8];
		end
		wait_drained();
		reg_write(REG_CHARS_LO, lo);
		reg_write(REG_CHARS_HI, hi);
		reg_write(REG_PAT_LEN, APB_W'(len_reg));
	endtask

	// mostly pattern copies with disjoint swaps, some filler and noise
	task automatic feed_text(input int n_items, input bit restarts);
		logic [CHAR_W-1:0] seg [MAX_PATTERN];
		logic [CHAR_W-1:0] t;
		bit                fresh;
		int                sent;
		int                i;
		int                r;
		int                cnt;
		fresh = 1'b1;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				for (i = 0; i < gen_len; i++) seg[i] = pat[i];
				for (i = 0; i + 1 < gen_len; i++) begin
					if ($urandom_range(0, 2) == 0) begin
						t = seg[i];
						seg[i] = seg[i + 1];
						seg[i + 1] = t;
						i++;
					end
				end
				if ($urandom_range(0, 4) == 0) begin
					seg[$urandom_range(0, gen_len - 1)] = alpha[$urandom_range(0, alpha_n - 1)];
				end
				for (i = 0; i < gen_len; i++) begin
					send_char(seg[i], fresh, ROW_PRED, '0);
					fresh = 1'b0;
				end
				sent += gen_len;
			end else if (r < 9) begin
				cnt = $urandom_range(1, 3);
				for (i = 0; i < cnt; i++) begin
					send_char(alpha[$urandom_range(0, alpha_n - 1)], fresh, ROW_PRED, '0);
					fresh = 1'b0;
				end
				sent += cnt;
			end else begin
				cnt = $urandom_range(1, 4);
				for (i = 0; i < cnt; i++) begin
					send_char(CHAR_W'($urandom),
						fresh | (restarts && $urandom_range(0, 7) == 0), ROW_PRED, '0);
					fresh = 1'b0;
				end
				sent += cnt;
			end
			if (restarts && $urandom_range(0, 24) == 0) fresh = 1'b1;
		end
	endtask

	always @(posedge clk) begin : result_check
		logic [START_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			start_count++;
			if (pending_starts.size() == 0) begin
				note_mismatch($sformatf("start_position %0d with no match pending",
					start_position));
			end else begin
				want = pending_starts.pop_front();
				if (start_position !== want) begin
					note_mismatch($sformatf("start_position: expected %0d, got %0d",
						want, start_position));
				end
			end
		end
	end

	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick % 300 == 0) stall_style = stall_style_e'($urandom_range(0, 2));
		case (stall_style)
			STALL_NONE: begin
				out_stall <= 1'b0;
			end
			STALL_SCATTER: begin
				out_stall <= ($urandom_range(0, 2) == 0);
			end
			default: begin
				if (stall_run > 0) begin
					stall_run--;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
					if ($urandom_range(0, 11) == 0) stall_run = $urandom_range(2, 20);
				end
			end
		endcase
	end

	initial begin
		int i;
		int ph;
		cfg_len = 5'd1;
		cfg_lo = '0;
		cfg_hi = '0;
		for (i = 0; i < MAX_PATTERN; i++) win[i] = '0;
		text_pos = 0;
		burst_left = 0;
		holding = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].kind == ROW_WRITE) begin
				wait_drained();
				reg_write(PLAN[i].idx, PLAN[i].value);
			end else begin
				send_char(PLAN[i].ch, PLAN[i].first, PLAN[i].kind, PLAN[i].at);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			set_pattern(PHASE_LENS[ph], ph % 2);
			feed_text(48, 1'b1);
			if (ph % 3 == 0) wait_drained();
			feed_text(48, 1'b1);
		end
		wait_drained();

		$display("Run covered %0d text bytes in %0d texts and %0d returned match starts,",
			byte_count, text_count, start_count);
		$display("pattern lengths 0 to 31, restarts inside texts and stalled results.");
		if (bad_count == 0) begin
			$display("PASS swap_tolerant_pattern_matcher");
		end else begin
			$display("FAIL swap_tolerant_pattern_matcher");
		end
		$finish;
	end

	initial begin
		#(8 * 1_500_000);
		$display("FAIL swap_tolerant_pattern_matcher");
		$finish;
	end

endmodule

// ----- swap_tolerant_pattern_matcher.f -----
hw/rtl/stpm_pkg.sv
hw/rtl/stpm_cfg.sv
hw/rtl/stpm_cell.sv
hw/rtl/swap_tolerant_pattern_matcher.sv
hw/rtl/stpm_checker.sv
test/tb_swap_tolerant_pattern_matcher.sv
